// ===== src/modular_exponentiation_macros.svh =====
// Assertion macros for the checker of the modular exponentiation block.
// No dependencies; include by bare file name.
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

// Clocked assertion, switched off while reset is asserted
`define MODEXP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define MODEXP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/modexp_pkg.sv =====
// Shared widths, register indexes and the modular shift-add step.
// No dependencies.
package modexp_pkg;

    localparam int MSG_W      = 64;
    localparam int MOD_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam int CNT_W      = $clog2(MSG_W);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd1;

    // One step of the bit-serial modular unit: (2*r + addend) mod m,
    // valid for r < m and addend < m (sum below 3*m).
    function automatic logic [MOD_W-1:0] mod_step(
        input logic [MOD_W-1:0] r,
        input logic [MOD_W-1:0] addend,
        input logic [MOD_W-1:0] m
    );
        logic [MOD_W+1:0] t;
        logic [MOD_W+1:0] mw;
        mw = {2'b00, m};
        t  = {1'b0, r, 1'b0} + {2'b00, addend};
        if (t >= mw) begin
            t = t - mw;
        end
        if (t >= mw) begin
            t = t - mw;
        end
        return t[MOD_W-1:0];
    endfunction

endpackage

// ===== src/modular_exponentiation.sv =====
// Top level: right-to-left square-and-multiply modular exponentiation.
// Depends on modexp_pkg.
//
//   channel  | ports                                 | direction
//   ---------+---------------------------------------+----------
//   input    | s_valid s_ready s_message_value       | in
//   result   | m_valid m_ready m_power_result        | out
//   config   | cfg_valid cfg_ready cfg_index cfg_data| in
//
// One item at a time. The base is reduced one message bit per cycle, then each
// modular multiply or square runs on the shared shift-add unit, one multiplier bit
// per cycle. A zero exponent or zero modulus skips straight to the result.
// Reset clears control and sets exponent and modulus to one; the datapath is not reset.
// A result waiting on m_ready holds in the output register; the block then stalls
// before loading the next result.
module modular_exponentiation
    import modexp_pkg::*;
#(
    parameter int EXP_BITS = 64
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [MSG_W-1:0]      s_message_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [MOD_W-1:0]      m_power_result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_EVAL,
        ST_MUL,
        ST_SQR,
        ST_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [EXP_BITS-1:0] exponent_reg, exponent_next;
    logic [MOD_W-1:0]    modulus_reg, modulus_next;
    logic [EXP_BITS-1:0] e_reg, e_next;
    logic [MOD_W-1:0]    acc_reg, acc_next;
    logic [MOD_W-1:0]    sq_reg, sq_next;
    logic [MOD_W-1:0]    r_reg, r_next;
    logic [MSG_W-1:0]    scan_reg, scan_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                m_valid_reg, m_valid_next;
    logic [MOD_W-1:0]    result_reg, result_next;

    logic [MOD_W-1:0]    addend;
    logic [MOD_W-1:0]    step_out;
    logic [EXP_BITS-1:0] e_shift;

    assign s_ready        = (state_reg == ST_IDLE);
    assign cfg_ready      = 1'b1;
    assign m_valid        = m_valid_reg;
    assign m_power_result = result_reg;
    assign e_shift        = e_reg >> 1;

    // Shared unit: reduction feeds one message bit, multiply feeds the base
    assign addend   = (state_reg == ST_REDUCE) ? {{(MOD_W-1){1'b0}}, scan_reg[MSG_W-1]}
                    : (scan_reg[MSG_W-1] ? sq_reg : '0);
    assign step_out = mod_step(r_reg, addend, modulus_reg);

    always_comb begin
        state_next    = state_reg;
        exponent_next = exponent_reg;
        modulus_next  = modulus_reg;
        e_next        = e_reg;
        acc_next      = acc_reg;
        sq_next       = sq_reg;
        r_next        = r_reg;
        scan_next     = scan_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        result_next   = result_reg;

        // Take configuration writes; indexes past the list are dropped
        if (cfg_valid) begin
            case (cfg_index)
                CFG_EXPONENT: exponent_next = cfg_data[EXP_BITS-1:0];
                CFG_MODULUS:  modulus_next  = cfg_data[MOD_W-1:0];
                default:      ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    e_next = exponent_reg;
                    if (exponent_reg == '0) begin
                        acc_next   = {{(MOD_W-1){1'b0}}, 1'b1};
                        state_next = ST_FINISH;
                    end else if (modulus_reg == '0) begin
                        acc_next   = '0;
                        state_next = ST_FINISH;
                    end else begin
                        acc_next   = {{(MOD_W-1){1'b0}}, 1'b1};
                        r_next     = '0;
                        scan_next  = s_message_value;
                        cnt_next   = CNT_W'(MSG_W - 1);
                        state_next = ST_REDUCE;
                    end
                end
            end
            // Reduce the message, most significant bit first
            ST_REDUCE: begin
                r_next    = step_out;
                scan_next = scan_reg << 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    sq_next    = step_out;
                    state_next = ST_EVAL;
                end
            end
            // Pick the next operation for the current exponent bit
            ST_EVAL: begin
                r_next   = '0;
                cnt_next = CNT_W'(MOD_W - 1);
                if (e_reg[0]) begin
                    scan_next  = {acc_reg, {(MSG_W-MOD_W){1'b0}}};
                    state_next = ST_MUL;
                end else begin
                    scan_next  = {sq_reg, {(MSG_W-MOD_W){1'b0}}};
                    state_next = ST_SQR;
                end
            end
            // acc = acc * sq mod m; skip the last square when no bits remain
            ST_MUL: begin
                r_next    = step_out;
                scan_next = scan_reg << 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    acc_next = step_out;
                    r_next   = '0;
                    cnt_next = CNT_W'(MOD_W - 1);
                    if (e_shift != '0) begin
                        scan_next  = {sq_reg, {(MSG_W-MOD_W){1'b0}}};
                        state_next = ST_SQR;
                    end else begin
                        state_next = ST_FINISH;
                    end
                end
            end
            // sq = sq * sq mod m, then advance to the next exponent bit
            ST_SQR: begin
                r_next    = step_out;
                scan_next = scan_reg << 1;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    sq_next    = step_out;
                    e_next     = e_shift;
                    state_next = ST_EVAL;
                end
            end
            // Hand the result to the output register once it is free
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    result_next  = acc_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            exponent_reg <= EXP_BITS'(1);
            modulus_reg  <= MOD_W'(1);
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            exponent_reg <= exponent_next;
            modulus_reg  <= modulus_next;
            m_valid_reg  <= m_valid_next;
        end
        e_reg      <= e_next;
        acc_reg    <= acc_next;
        sq_reg     <= sq_next;
        r_reg      <= r_next;
        scan_reg   <= scan_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

endmodule

// ===== src/modexp_checker.sv =====
// Port-level checks for modular_exponentiation, attached by bind.
// Depends on modexp_pkg and modular_exponentiation_macros.svh.
`include "modular_exponentiation_macros.svh"

module modexp_checker
    import modexp_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [MOD_W-1:0]      m_power_result
);

    // A stalled result transaction holds its value
    `MODEXP_ASSERT(a_result_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_power_result), "result changed while stalled")

    // The block goes busy right after taking an input transaction
    `MODEXP_ASSERT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready, "input accepted while busy")

    // No result appears in the cycle right after an input transaction
    `MODEXP_ASSERT(a_no_instant_result, aclk, aresetn, s_valid && s_ready |=> !$rose(m_valid), "result too early")

    // Reset empties the output register
    `MODEXP_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind modular_exponentiation modexp_checker u_modexp_checker (.*);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for modular_exponentiation: directed rows, then randomized key phases, each result
// checked against a typed value or a square-and-multiply predictor. Depends on modexp_pkg.
module tb_top
    import modexp_pkg::*;
();

    localparam int EXP_BITS        = 64;
    localparam logic [63:0] EXP_MASK = {64{1'b1}} >> (64 - EXP_BITS);
    localparam int IDLE_SETTLE     = 8;
    localparam int TAIL_CYCLES     = 64;
    localparam int HOLDOFF_CYCLES  = 2500;
    localparam int PHASES          = 16;
    localparam int ITEMS_PER_PHASE = 137;
    localparam int FULL_EXP_ITEMS  = 10;
    localparam int TIMEOUT_NS      = 25_000_000;

    // Indexes past the last register; the block must ignore writes to them
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef enum logic [0:0] {ROW_MSG, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [63:0]           value;
        logic                  typed;
        logic [MOD_W-1:0]      result;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 31;

    // Directed rows: message rows carry a typed result only where it is obvious
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // after reset: exponent 1, modulus 1
        '{ROW_MSG, CFG_EXPONENT, 64'd0,                  1'b1, 32'd0},
        '{ROW_MSG, CFG_EXPONENT, {64{1'b1}},             1'b1, 32'd0},
        // zero exponent with modulus one
        '{ROW_CFG, CFG_EXPONENT, 64'd0,                  1'b0, 32'd0},
        '{ROW_MSG, CFG_EXPONENT, 64'd5,                  1'b1, 32'd1},
        // widest modulus, upper data bits must be dropped
        '{ROW_CFG, CFG_MODULUS,  64'hA5A5_5A5A_FFFF_FFFF, 1'b0, 32'd0},
        '{ROW_MSG, CFG_EXPONENT, {64{1'b1}},             1'b1, 32'd1},
        '{ROW_CFG, CFG_EXPONENT, 64'd1,                  1'b0, 32'd0},
        '{ROW_MSG, CFG_EXPONENT, {64{1'b1}},             1'b0, 32'd0},
        '{ROW_MSG, CFG_EXPONENT, 64'h0000_0001_2345_6789, 1'b0, 32'd0},
        '{ROW_MSG, CFG_EXPONENT, 64'h0000_0000_FFFF_FFFE, 1'b1, 32'hFFFF_FFFE},
        // full exponent
        '{ROW_CFG, CFG_EXPONENT, {64{1'b1}},             1'b0, 32'd0},
        '{ROW_MSG, CFG_EXPONENT, 64'd0,                  1'b1, 32'd0},
        '{ROW_MSG, CFG_EXPONENT, 64'd1,                  1'b1, 32'd1},
        '{ROW_MSG, CFG_EXPONENT, {64{1'b1}},             1'b0, 32'd0},
        '{ROW_MSG, CFG_EXPONENT, 64'h8000_0000_0000_0000, 1'b0, 32'd0},
        // zero modulus gives zero for a nonzero exponent
        '{ROW_CFG, CFG_MODULUS,  64'hFFFF_FFFF_0000_0000, 1'b0, 32'd0},
        '{ROW_MSG, CFG_EXPONENT, 64'd12345,              1'b1, 32'd0},
        '{ROW_MSG, CFG_EXPONENT, {64{1'b1}},             1'b1, 32'd0},
        // writes past the last register change nothing
        '{ROW_CFG, CFG_SPARE_A,  {64{1'b1}},             1'b0, 32'd0},
        '{ROW_CFG, CFG_SPARE_B,  64'h0000_0000_0000_1234, 1'b0, 32'd0},
        '{ROW_MSG, CFG_EXPONENT, 64'd7,                  1'b1, 32'd0},
        // zero exponent together with zero modulus
        '{ROW_CFG, CFG_EXPONENT, 64'd0,                  1'b0, 32'd0},
        '{ROW_MSG, CFG_EXPONENT, 64'd9,                  1'b0, 32'd0},
        // only the top exponent bit set
        '{ROW_CFG, CFG_MODULUS,  64'd13,                 1'b0, 32'd0},
        '{ROW_CFG, CFG_EXPONENT, 64'h8000_0000_0000_0000, 1'b0, 32'd0},
        '{ROW_MSG, CFG_EXPONENT, 64'd3,                  1'b0, 32'd0},
        '{ROW_MSG, CFG_EXPONENT, 64'd13,                 1'b1, 32'd0},
        // parity under modulus two
        '{ROW_CFG, CFG_MODULUS,  64'd2,                  1'b0, 32'd0},
        '{ROW_CFG, CFG_EXPONENT, 64'd3,                  1'b0, 32'd0},
        '{ROW_MSG, CFG_EXPONENT, {64{1'b1}},             1'b1, 32'd1},
        '{ROW_MSG, CFG_EXPONENT, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1, 32'd0}
    };

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [MSG_W-1:0]      s_message_value = '0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [MOD_W-1:0]      m_power_result;
    logic                  cfg_valid       = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [CFG_DATA_W-1:0] cfg_data        = '0;

    // Key as the testbench believes the block holds it
    logic [63:0]           key_exponent = 64'd1;
    logic [MOD_W-1:0]      key_modulus  = 32'd1;

    logic [MOD_W-1:0]      offered_power = '0;
    logic [MOD_W-1:0]      pending_powers [$];
    int                    fail_count     = 0;
    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    int                    holdoff_serial = 0;
    int                    holdoff_seen   = 0;
    int                    holdoff_left   = 0;

    modular_exponentiation #(
        .EXP_BITS (EXP_BITS)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_message_value (s_message_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_power_result  (m_power_result),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Square-and-multiply from the least significant exponent bit up
    function automatic logic [MOD_W-1:0] predict_power(input logic [MSG_W-1:0] msg);
        logic [63:0] e;
        logic [63:0] acc;
        logic [63:0] base;
        e = key_exponent & EXP_MASK;
        if (e == 64'd0) begin
            return 32'd1;
        end
        if (key_modulus == 32'd0) begin
            return 32'd0;
        end
        acc  = 64'd1;
        base = msg % {32'd0, key_modulus};
        for (int i = 0; i < EXP_BITS; i++) begin
            if (e[i]) begin
                acc = (acc * base) % {32'd0, key_modulus};
            end
            base = (base * base) % {32'd0, key_modulus};
        end
        return acc[MOD_W-1:0];
    endfunction

    // Drop valid and wait until every outstanding result has been taken
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_powers.size() != 0) begin
            @(posedge aclk);
        end
        repeat (IDLE_SETTLE) @(posedge aclk);
    endtask

    // Write one register once the block is idle, then track it
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_EXPONENT: key_exponent = data;
            CFG_MODULUS:  key_modulus  = data[MOD_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one message after a random gap; return at the accepting edge
    task automatic send_message(input logic [MSG_W-1:0] msg, input logic [MOD_W-1:0] power);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        offered_power   <= power;
        s_valid         <= 1'b1;
        s_message_value <= msg;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [MSG_W-1:0] pick_message();
        case ($urandom_range(9))
            0:       return '0;
            1:       return {MSG_W{1'b1}};
            2:       return {32'd0, key_modulus};
            3:       return {32'd0, key_modulus} - 64'd1;
            4:       return 64'($urandom_range(3));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    function automatic logic [MOD_W-1:0] pick_modulus(input int phase);
        logic [MOD_W-1:0] m;
        case (phase)
            0:       m = 32'hFFFF_FFFF;
            3:       m = 32'd1;
            7:       m = 32'd2;
            10:      m = 32'd0;
            14:      m = 32'h8000_0000;
            default: begin
                m = $urandom() >> $urandom_range(0, 31);
                if (m == 32'd0) begin
                    m = 32'd3;
                end
            end
        endcase
        return m;
    endfunction

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (holdoff_serial != holdoff_seen) begin
            holdoff_seen = holdoff_serial;
            holdoff_left = HOLDOFF_CYCLES;
        end
        if (holdoff_left > 0) begin
            holdoff_left = holdoff_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Check each result transaction, then record each accepted message
    always @(posedge aclk) begin
        logic [MOD_W-1:0] want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_powers.size() == 0) begin
                    $error("power_result: no result expected, actual %0h", m_power_result);
                    fail_count = fail_count + 1;
                end else begin
                    want = pending_powers.pop_front();
                    if (m_power_result !== want) begin
                        $error("power_result: expected %0h, actual %0h", want, m_power_result);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                pending_powers.push_back(offered_power);
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_top failed");
        $finish;
    end

    initial begin
        logic [MSG_W-1:0] msg;
        logic [63:0]      e;
        int               n_items;
        int               w;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed rows, no idling
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_CFG) begin
                write_register(directed_rows[r].idx, directed_rows[r].value);
            end else begin
                msg = directed_rows[r].value;
                send_message(msg, directed_rows[r].typed ? directed_rows[r].result
                                                         : predict_power(msg));
            end
        end

        // Random phases: new key each phase, idling pattern cycles through four modes
        for (int p = 0; p < PHASES; p++) begin
            if (p == 5 || p == 12) begin
                e = {$urandom(), $urandom()};
                if (p == 12) begin
                    e[63] = 1'b1;
                end
                n_items = FULL_EXP_ITEMS;
            end else if (p == 8) begin
                e       = 64'd0;
                n_items = ITEMS_PER_PHASE;
            end else begin
                w       = $urandom_range(1, 6);
                e       = {32'd0, $urandom()} & ((64'd1 << w) - 64'd1);
                n_items = ITEMS_PER_PHASE;
            end
            write_register(CFG_EXPONENT, e);
            write_register(CFG_MODULUS, {$urandom(), pick_modulus(p)});
            if (p == 4) begin
                write_register(CFG_SPARE_A, {$urandom(), $urandom()});
            end

            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 30; recv_stall_pct = 30; end
            endcase

            // Hold the result channel off while messages keep coming
            if (p == 2) begin
                holdoff_serial = holdoff_serial + 1;
            end

            for (int i = 0; i < n_items; i++) begin
                if (p == 9 && i == n_items / 2) begin
                    wait_drained();
                end
                msg = pick_message();
                send_message(msg, predict_power(msg));
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
